FILE: src/ccr_pkg.sv
// Shared types, stream widths and arithmetic step functions for the circle collision resolver.
package ccr_pkg;

	// Stream widths in bits, padded to whole bytes
	localparam int IN_W  = 256;
	localparam int OUT_W = 136;

	// Item context that travels down the pipeline beside the arithmetic lanes
	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [31:0] x2;
		logic signed [31:0] y2;
		logic [30:0]        m1;
		logic [30:0]        m2;
		logic               p1;
		logic               p2;
		logic               negx;
		logic               negy;
		logic               hit;
		logic               dz;
		logic [31:0]        t;
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic [31:0]        d;
		logic [31:0]        ov;
		logic [31:0]        sx;
		logic [31:0]        sy;
		logic [31:0]        msum;
	} ctx_t;

	// Square root lane: partial remainder, partial root, radicand bits still to consume
	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_t;

	// Divider lane: partial remainder and dividend low word that turns into the quotient
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] lo;
	} div_t;

	// One root bit per step, two radicand bits consumed
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		sqrt_t       r;
		logic [35:0] sh;
		logic [35:0] trial;
		sh    = {a.rem, a.rad[63:62]};
		trial = {2'b00, a.root, 2'b01};
		r.rad = {a.rad[61:0], 2'b00};
		if (sh >= trial) begin
			r.rem  = 34'(sh - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = sh[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// One restoring quotient bit per step; a remainder below the divisor stays below it
	function automatic div_t div_step(input div_t a, input logic [31:0] den);
		div_t        r;
		logic [32:0] sh;
		sh = {a.rem, a.lo[31]};
		if (sh >= {1'b0, den}) begin
			r.rem = 32'(sh - {1'b0, den});
			r.lo  = {a.lo[30:0], 1'b1};
		end else begin
			r.rem = sh[31:0];
			r.lo  = {a.lo[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: src/circle_collision_resolver_unit.sv
// Depth: 106 register stages; an item enters stage 1 at its accept edge and its result is
// offered on the master side from the stage 106 register. Throughput: one circle pair
// per cycle unless the master side stalls; the depth is set by the 32-step root
// extraction and the two 32-step restoring divider chains (one quotient bit per stage).
// A master-side stall holds every stage in place; s_tready follows the output register.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
module circle_collision_resolver_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// first_x[31:0], first_y[63:32], first_radius[94:64], first_mass[125:95],
	// first_pinned[126], second_x[158:127], second_y[190:159], second_radius[221:191],
	// second_mass[252:222], second_pinned[253], zero pad[255:254]
	input  logic [ccr_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// new_first_x[31:0], new_first_y[63:32], new_second_x[95:64], new_second_y[127:96],
	// overlapping[128], zero pad[135:129]
	output logic [ccr_pkg::OUT_W-1:0] m_tdata
);
	import ccr_pkg::*;

	localparam int SQ_N = 32;
	localparam int DV_N = 32;

	logic ce;

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s38, v_s72, out_valid_s106;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s38, ctx_s72;
	logic [32:0] dx_s1, dy_s1;
	logic ltx_s2, lty_s2, lt_s3, lt_s4, alt_s4;
	logic [63:0] a_s3, b_s3, t2_s3, b_s4, diff_s4;

	logic [SQ_N:0] sq_v_s;
	ctx_t          sq_ctx_s [0:SQ_N];
	sqrt_t         sq_s     [0:SQ_N];
	logic [31:0]   root_s37;
	logic [DV_N:0] dv_v_s;
	ctx_t          dv_ctx_s [0:DV_N];
	div_t          dv_s     [0:DV_N][0:1];
	logic [DV_N:0] pt_v_s;
	ctx_t          pt_ctx_s [0:DV_N];
	div_t          pt_s     [0:DV_N][0:3];
	logic [OUT_W-1:0] out_data_s106;

	// combinational next values
	ctx_t        c1_d, c2_d, c5_d, c38_d, c72_d, cf;
	logic [32:0] ax_w, ay_w;
	logic [63:0] mx_w, my_w;
	logic [63:0] p_w [0:3];
	logic [31:0] fx, fy, gx, gy;
	logic [31:0] nx1, ny1, nx2, ny2;
	logic        act;

	// Add or subtract a magnitude and clamp to the 32-bit signed range
	function automatic logic [31:0] move_sat(input logic [31:0] base, input logic [31:0] mag,
			input logic sub);
		logic [33:0] b;
		logic [33:0] m;
		logic [33:0] s;
		logic [31:0] r;
		b = {{2{base[31]}}, base};
		m = {2'b00, mag};
		s = sub ? (b - m) : (b + m);
		r = s[31:0];
		if (!s[33] && (s[32:31] != 2'b00)) begin
			r = 32'h7fff_ffff;
		end else if (s[33] && (s[32:31] != 2'b11)) begin
			r = 32'h8000_0000;
		end
		return r;
	endfunction

	// Advance everything together; hold the whole pipe while the output waits
	assign ce       = !out_valid_s106 || m_tready;
	assign s_tready = ce;
	assign m_tvalid = out_valid_s106;
	assign m_tdata  = out_data_s106;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			sq_v_s         <= '0;
			v_s38          <= 1'b0;
			dv_v_s         <= '0;
			v_s72          <= 1'b0;
			pt_v_s         <= '0;
			out_valid_s106 <= 1'b0;
		end else if (ce) begin
			v_s1           <= s_tvalid;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			sq_v_s         <= {sq_v_s[SQ_N-1:0], v_s4};
			v_s38          <= sq_v_s[SQ_N];
			dv_v_s         <= {dv_v_s[DV_N-1:0], v_s38};
			v_s72          <= dv_v_s[DV_N];
			pt_v_s         <= {pt_v_s[DV_N-1:0], v_s72};
			out_valid_s106 <= pt_v_s[DV_N];
		end
	end

	// Stage 1: unpack, radius sum, centre differences
	always_comb begin
		c1_d    = '0;
		c1_d.x1 = s_tdata[31:0];
		c1_d.y1 = s_tdata[63:32];
		c1_d.m1 = s_tdata[125:95];
		c1_d.p1 = s_tdata[126];
		c1_d.x2 = s_tdata[158:127];
		c1_d.y2 = s_tdata[190:159];
		c1_d.m2 = s_tdata[252:222];
		c1_d.p2 = s_tdata[253];
		c1_d.t  = {1'b0, s_tdata[94:64]} + {1'b0, s_tdata[221:191]};
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s1 <= c1_d;
			dx_s1  <= {s_tdata[31], s_tdata[31:0]} - {s_tdata[158], s_tdata[158:127]};
			dy_s1  <= {s_tdata[63], s_tdata[63:32]} - {s_tdata[190], s_tdata[190:159]};
		end
	end

	// Stage 2: magnitudes and the per-axis early reject
	always_comb begin
		ax_w      = dx_s1[32] ? 33'(~dx_s1 + 33'd1) : dx_s1;
		ay_w      = dy_s1[32] ? 33'(~dy_s1 + 33'd1) : dy_s1;
		c2_d      = ctx_s1;
		c2_d.ax   = ax_w[31:0];
		c2_d.ay   = ay_w[31:0];
		c2_d.negx = dx_s1[32];
		c2_d.negy = dy_s1[32];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s2 <= c2_d;
			ltx_s2 <= ax_w < {1'b0, ctx_s1.t};
			lty_s2 <= ay_w < {1'b0, ctx_s1.t};
		end
	end

	// Stage 3: squares
	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s3 <= ctx_s2;
			lt_s3  <= ltx_s2 && lty_s2;
			a_s3   <= ctx_s2.ax * ctx_s2.ax;
			b_s3   <= ctx_s2.ay * ctx_s2.ay;
			t2_s3  <= ctx_s2.t * ctx_s2.t;
		end
	end

	// Stage 4: headroom below the squared radius sum, squared distance
	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s4  <= ctx_s3;
			lt_s4   <= lt_s3;
			alt_s4  <= a_s3 < t2_s3;
			diff_s4 <= t2_s3 - a_s3;
			b_s4    <= b_s3;
			sq_s[0].rad <= a_s3 + b_s3;
		end
	end

	// Stage 5: overlap decision, root extraction starts
	always_comb begin
		c5_d     = ctx_s4;
		c5_d.hit = lt_s4 && alt_s4 && (b_s4 < diff_s4);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sq_ctx_s[0] <= c5_d;
			sq_s[1]     <= sqrt_step('{rem: '0, root: '0, rad: sq_s[0].rad});
		end
	end

	// Root extraction, one bit per stage
	for (genvar k = 1; k < SQ_N; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (ce) begin
				sq_ctx_s[k]  <= sq_ctx_s[k-1];
				sq_s[k+1]    <= sqrt_step(sq_s[k]);
			end
		end
	end

	// Stage 37: hold the finished root beside its item
	always_ff @(posedge clk) begin
		if (ce) begin
			sq_ctx_s[SQ_N] <= sq_ctx_s[SQ_N-1];
			root_s37       <= sq_s[SQ_N].root;
		end
	end

	// Stage 38: overlap depth along the line of centres
	always_comb begin
		c38_d    = sq_ctx_s[SQ_N];
		c38_d.d  = root_s37;
		c38_d.ov = sq_ctx_s[SQ_N].t - root_s37;
		c38_d.dz = root_s37 == '0;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s38 <= c38_d;
		end
	end

	// Stage 39: scale magnitudes by the overlap, load the divider lanes
	assign mx_w = ctx_s38.ax * ctx_s38.ov;
	assign my_w = ctx_s38.ay * ctx_s38.ov;

	always_ff @(posedge clk) begin
		if (ce) begin
			dv_ctx_s[0] <= ctx_s38;
			dv_s[0][0]  <= '{rem: mx_w[63:32], lo: mx_w[31:0]};
			dv_s[0][1]  <= '{rem: my_w[63:32], lo: my_w[31:0]};
		end
	end

	// Divide by the distance, one quotient bit per stage
	for (genvar k = 0; k < DV_N; k++) begin : g_dist_div
		always_ff @(posedge clk) begin
			if (ce) begin
				dv_ctx_s[k+1] <= dv_ctx_s[k];
				dv_s[k+1][0]  <= div_step(dv_s[k][0], dv_ctx_s[k].d);
				dv_s[k+1][1]  <= div_step(dv_s[k][1], dv_ctx_s[k].d);
			end
		end
	end

	// Stage 72: full shift, +x direction for coincident centres, mass sum
	always_comb begin
		c72_d      = dv_ctx_s[DV_N];
		c72_d.sx   = dv_ctx_s[DV_N].dz ? dv_ctx_s[DV_N].ov : dv_s[DV_N][0].lo;
		c72_d.sy   = dv_ctx_s[DV_N].dz ? '0 : dv_s[DV_N][1].lo;
		c72_d.negx = dv_ctx_s[DV_N].negx && !dv_ctx_s[DV_N].dz;
		c72_d.negy = dv_ctx_s[DV_N].negy && !dv_ctx_s[DV_N].dz;
		c72_d.msum = {1'b0, dv_ctx_s[DV_N].m1} + {1'b0, dv_ctx_s[DV_N].m2};
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctx_s72 <= c72_d;
		end
	end

	// Stage 73: weight shifts by the opposite mass, load the share dividers
	assign p_w[0] = ctx_s72.sx * {1'b0, ctx_s72.m2};
	assign p_w[1] = ctx_s72.sy * {1'b0, ctx_s72.m2};
	assign p_w[2] = ctx_s72.sx * {1'b0, ctx_s72.m1};
	assign p_w[3] = ctx_s72.sy * {1'b0, ctx_s72.m1};

	always_ff @(posedge clk) begin
		if (ce) begin
			pt_ctx_s[0] <= ctx_s72;
			for (int j = 0; j < 4; j++) begin
				pt_s[0][j] <= '{rem: p_w[j][63:32], lo: p_w[j][31:0]};
			end
		end
	end

	// Divide by the mass sum, one quotient bit per stage
	for (genvar k = 0; k < DV_N; k++) begin : g_mass_div
		always_ff @(posedge clk) begin
			if (ce) begin
				pt_ctx_s[k+1] <= pt_ctx_s[k];
				for (int j = 0; j < 4; j++) begin
					pt_s[k+1][j] <= div_step(pt_s[k][j], pt_ctx_s[k].msum);
				end
			end
		end
	end

	// Stage 106: pick shares by pinning, apply with saturation
	always_comb begin
		cf = pt_ctx_s[DV_N];
		if (cf.p1) begin
			fx = '0;
			fy = '0;
			gx = cf.sx;
			gy = cf.sy;
		end else if (cf.p2) begin
			fx = cf.sx;
			fy = cf.sy;
			gx = '0;
			gy = '0;
		end else if (cf.msum == '0) begin
			fx = {1'b0, cf.sx[31:1]};
			fy = {1'b0, cf.sy[31:1]};
			gx = {1'b0, cf.sx[31:1]};
			gy = {1'b0, cf.sy[31:1]};
		end else begin
			fx = pt_s[DV_N][0].lo;
			fy = pt_s[DV_N][1].lo;
			gx = pt_s[DV_N][2].lo;
			gy = pt_s[DV_N][3].lo;
		end
		act = cf.hit && !(cf.p1 && cf.p2);
		nx1 = cf.x1;
		ny1 = cf.y1;
		nx2 = cf.x2;
		ny2 = cf.y2;
		if (act) begin
			nx1 = move_sat(cf.x1, fx, cf.negx);
			ny1 = move_sat(cf.y1, fy, cf.negy);
			nx2 = move_sat(cf.x2, gx, !cf.negx);
			ny2 = move_sat(cf.y2, gy, !cf.negy);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_data_s106 <= {7'd0, cf.hit, ny2, nx2, ny1, nx1};
		end
	end

endmodule

FILE: src/ccr_checker.sv
// Port-level checker for the circle collision resolver and its bind.
module ccr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ccr_pkg::OUT_W-1:0] m_tdata
);
	import ccr_pkg::*;

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Input side moves exactly when the output register can drain
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output drain");

	// No result is offered when reset is released
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result offered right after reset");

	// No result can appear in the cycle right after reset release
	a_reset_latency: assert property (@(posedge clk)
		$rose(arst_n) |=> !m_tvalid)
		else $error("result appeared before pipeline depth elapsed");

endmodule

bind circle_collision_resolver_unit ccr_checker u_ccr_checker (.*);
